FILE: sv/mfdl_pkg.sv
// Shared types, constants and helpers for the modulated feedback delay line.
package mfdl_pkg;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_DELAY_TIME      = 3'd0;
    localparam logic [2:0] REG_FEEDBACK_AMOUNT = 3'd1;
    localparam logic [2:0] REG_WET_MIX         = 3'd2;
    localparam logic [2:0] REG_SAMPLE_RATE     = 3'd3;
    localparam logic [2:0] REG_SMOOTHING_COEFF = 3'd4;

    localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
    localparam logic [15:0] SMOOTHING_RST   = 16'd2621;

    // 0.002 s in 2^-20 s units, and 0.95 in Q0.16
    localparam logic signed [12:0] MOD_SCALE = 13'sd2097;
    localparam logic [15:0]        FB_CEIL   = 16'd62259;

    typedef struct packed {
        logic [15:0] delay_time;
        logic [15:0] feedback_amount;
        logic [15:0] wet_mix;
        logic [17:0] sample_rate;
        logic [15:0] smoothing_coeff;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT1,
        ST_DIFF,
        ST_SMUL,
        ST_SUPD,
        ST_OMUL,
        ST_OCLAMP,
        ST_RPOS,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_SMP,
        ST_MIXM,
        ST_OUT
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/mfdl_ram.sv
// Sample store: one write port, one read port with registered read data.
module mfdl_ram #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [15:0]   rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [15:0]   wr_data
);

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/mfdl_cfg.sv
// APB register file for the delay line settings.
module mfdl_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mfdl_pkg::cfg_t     cfg
);

    mfdl_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_strobe;

    assign idx       = paddr[4:2];
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_time      <= '0;
            cfg_reg.feedback_amount <= '0;
            cfg_reg.wet_mix         <= '0;
            cfg_reg.sample_rate     <= mfdl_pkg::SAMPLE_RATE_RST;
            cfg_reg.smoothing_coeff <= mfdl_pkg::SMOOTHING_RST;
        end else if (wr_strobe) begin
            case (idx)
                mfdl_pkg::REG_DELAY_TIME:      cfg_reg.delay_time      <= pwdata[15:0];
                mfdl_pkg::REG_FEEDBACK_AMOUNT: cfg_reg.feedback_amount <= pwdata[15:0];
                mfdl_pkg::REG_WET_MIX:         cfg_reg.wet_mix         <= pwdata[15:0];
                mfdl_pkg::REG_SAMPLE_RATE:     cfg_reg.sample_rate     <= pwdata[17:0];
                mfdl_pkg::REG_SMOOTHING_COEFF: cfg_reg.smoothing_coeff <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            mfdl_pkg::REG_DELAY_TIME:      prdata = {16'd0, cfg_reg.delay_time};
            mfdl_pkg::REG_FEEDBACK_AMOUNT: prdata = {16'd0, cfg_reg.feedback_amount};
            mfdl_pkg::REG_WET_MIX:         prdata = {16'd0, cfg_reg.wet_mix};
            mfdl_pkg::REG_SAMPLE_RATE:     prdata = {14'd0, cfg_reg.sample_rate};
            mfdl_pkg::REG_SMOOTHING_COEFF: prdata = {16'd0, cfg_reg.smoothing_coeff};
            default:                       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/modulated_feedback_delay_line.sv
// Modulated feedback delay line: one sample in, one sample out. A sequencer walks
// each sample through the delay-time smoothing multiply chain, two reads of the
// single-read-port sample store (older and newer tap), one write back of input plus
// feedback, and the wet/dry mix; the next sample is taken when the sequencer is back
// in idle, while a finished result may still wait in the output register. The store
// needs no clearing pass after reset: a fill pointer and a wrapped flag make
// never-written entries read as zero.
module modulated_feedback_delay_line #(
    parameter int DELAY_DEPTH = 131072
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input samples
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [15:0] audio_in, [31:16] mod_in
    input  logic         s_tlast,   // block_last
    // output samples
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [15:0] audio_out
    output logic         m_tlast,   // out_last
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int OFW = AW + 16;
    localparam int RPW = AW + 17;
    localparam logic [37:0]    MAX_OFF  = 38'(DELAY_DEPTH - 2) << 16;
    localparam logic [RPW-1:0] DEPTH_Q  = RPW'(DELAY_DEPTH) << 16;
    localparam logic [AW-1:0]  LAST_IDX = AW'(DELAY_DEPTH - 1);

    mfdl_pkg::cfg_t   cfg;
    mfdl_pkg::state_t state_reg, state_next;

    // control outputs of the sequencer
    logic          mem_rd_en;
    logic          mem_rd_sel;
    logic          mem_wr_en;
    logic          out_load;
    logic [AW-1:0] rd_addr;

    // sample state
    logic [AW-1:0]      wp_reg;
    logic               full_reg;
    logic signed [23:0] smoothed_reg;
    logic signed [15:0] fed_back_reg;

    // per-sample payload
    logic signed [15:0] x_reg;
    logic signed [15:0] mod_reg;
    logic               last_reg;
    logic signed [28:0] modp_reg;
    logic [31:0]        fbp_reg;
    logic signed [25:0] diff_reg;
    logic signed [32:0] fbprod_reg;
    logic signed [41:0] sprod_reg;
    logic signed [15:0] wval_reg;
    logic signed [42:0] oprod_reg;
    logic [OFW-1:0]     off_reg;
    logic [OFW-1:0]     rp_reg;
    logic               rdv_reg;
    logic signed [15:0] y0_reg;
    logic signed [33:0] iprod_reg;
    logic signed [15:0] smp_reg;
    logic signed [33:0] px_reg;
    logic signed [33:0] ps_reg;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;
    logic               m_tlast_reg;

    logic signed [15:0] rd_data;

    // combinational datapath
    logic signed [28:0]  modp_next;
    logic [31:0]         fbp_next;
    logic [15:0]         fbg;
    logic signed [28:0]  modr;
    logic signed [25:0]  diff_next;
    logic signed [32:0]  fbprod_next;
    logic signed [32:0]  fbt;
    logic signed [15:0]  wval_next;
    logic signed [41:0]  sprod_next;
    logic signed [23:0]  snew;
    logic signed [42:0]  oprod_next;
    logic [37:0]         offs;
    logic [OFW-1:0]      off_next;
    logic signed [RPW-1:0] rp_raw;
    logic [RPW-1:0]      rp_wrap;
    logic [AW-1:0]       ip;
    logic [15:0]         frac;
    logic [AW-1:0]       i0;
    logic                rdv_next;
    logic signed [15:0]  qv;
    logic signed [16:0]  dy;
    logic signed [33:0]  iprod_next;
    logic signed [33:0]  smp_full;
    logic signed [15:0]  smp_next;
    logic signed [17:0]  dry;
    logic signed [33:0]  px_next;
    logic signed [33:0]  ps_next;
    logic signed [34:0]  y_sum;
    logic signed [15:0]  y_next;
    logic [AW-1:0]       wp_next;

    mfdl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfdl_ram #(
        .DEPTH (DELAY_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (wp_reg),
        .wr_data (wval_reg)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mfdl_pkg::ST_IDLE:   if (s_tvalid) state_next = mfdl_pkg::ST_MULT1;
            mfdl_pkg::ST_MULT1:  state_next = mfdl_pkg::ST_DIFF;
            mfdl_pkg::ST_DIFF:   state_next = mfdl_pkg::ST_SMUL;
            mfdl_pkg::ST_SMUL:   state_next = mfdl_pkg::ST_SUPD;
            mfdl_pkg::ST_SUPD:   state_next = mfdl_pkg::ST_OMUL;
            mfdl_pkg::ST_OMUL:   state_next = mfdl_pkg::ST_OCLAMP;
            mfdl_pkg::ST_OCLAMP: state_next = mfdl_pkg::ST_RPOS;
            mfdl_pkg::ST_RPOS:   state_next = mfdl_pkg::ST_RD0;
            mfdl_pkg::ST_RD0:    state_next = mfdl_pkg::ST_RD1;
            mfdl_pkg::ST_RD1:    state_next = mfdl_pkg::ST_INTERP;
            mfdl_pkg::ST_INTERP: state_next = mfdl_pkg::ST_SMP;
            mfdl_pkg::ST_SMP:    state_next = mfdl_pkg::ST_MIXM;
            mfdl_pkg::ST_MIXM:   state_next = mfdl_pkg::ST_OUT;
            mfdl_pkg::ST_OUT:    if (!m_tvalid_reg || m_tready) state_next = mfdl_pkg::ST_IDLE;
            default:             state_next = mfdl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        mem_rd_en  = 1'b0;
        mem_rd_sel = 1'b0;
        mem_wr_en  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            mfdl_pkg::ST_IDLE:   s_tready = 1'b1;
            mfdl_pkg::ST_RD0:    mem_rd_en = 1'b1;
            mfdl_pkg::ST_RD1: begin
                mem_rd_en  = 1'b1;
                mem_rd_sel = 1'b1;
            end
            mfdl_pkg::ST_INTERP: mem_wr_en = 1'b1;
            mfdl_pkg::ST_OUT:    out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfdl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- datapath ----------------
    // delay target and feedback gain
    assign modp_next   = 29'(mod_reg) * 29'(mfdl_pkg::MOD_SCALE);
    assign fbp_next    = 32'(cfg.feedback_amount) * 32'(mfdl_pkg::FB_CEIL);
    assign fbg         = 16'((33'(fbp_reg) + 33'd32768) >> 16);
    assign modr        = (modp_reg + 29'sd16384) >>> 15;
    assign diff_next   = $signed({6'd0, cfg.delay_time, 4'd0}) + 26'(modr)
                         - 26'(smoothed_reg);
    assign fbprod_next = 33'(fed_back_reg) * 33'($signed({1'b0, fbg}));
    assign fbt         = (fbprod_reg + 33'sd32768) >>> 16;
    assign wval_next   = mfdl_pkg::sat16(40'(x_reg) + 40'(fbt));

    // one-pole smoothing, wraps to 24 bits
    assign sprod_next = 42'($signed({1'b0, cfg.smoothing_coeff})) * 42'(diff_reg);
    assign snew       = 24'(42'(smoothed_reg) + ((sprod_reg + 42'sd32768) >>> 16));

    // time to fractional read offset
    assign oprod_next = 43'(smoothed_reg) * 43'($signed({1'b0, cfg.sample_rate}));
    assign offs       = oprod_reg[41:4];
    always_comb begin
        if (oprod_reg[42]) begin
            off_next = '0;
        end else if (offs > MAX_OFF) begin
            off_next = MAX_OFF[OFW-1:0];
        end else begin
            off_next = offs[OFW-1:0];
        end
    end

    assign rp_raw  = $signed({1'b0, wp_reg, 16'd0}) - $signed({1'b0, off_reg});
    assign rp_wrap = rp_raw[RPW-1] ? (rp_raw + DEPTH_Q) : rp_raw;

    // taps: older at ip-1 (wrapping), newer at ip
    assign ip      = rp_reg[OFW-1:16];
    assign frac    = rp_reg[15:0];
    assign i0      = (ip == '0) ? LAST_IDX : (ip - 1'b1);
    assign rd_addr = mem_rd_sel ? ip : i0;
    // entries not yet written since reset read as zero
    assign rdv_next = full_reg || (rd_addr < wp_reg);
    assign qv       = rdv_reg ? rd_data : 16'sd0;

    assign dy         = 17'(qv) - 17'(y0_reg);
    assign iprod_next = 34'(dy) * 34'($signed({1'b0, frac}));
    assign smp_full   = 34'(y0_reg) + ((iprod_reg + 34'sd32768) >>> 16);
    assign smp_next   = mfdl_pkg::sat16(40'(smp_full));

    // wet/dry mix
    assign dry     = 18'sd65536 - $signed({2'b0, cfg.wet_mix});
    assign px_next = 34'(x_reg) * 34'(dry);
    assign ps_next = 34'(smp_reg) * 34'($signed({1'b0, cfg.wet_mix}));
    assign y_sum   = 35'(px_reg) + 35'(ps_reg) + 35'sd32768;
    assign y_next  = mfdl_pkg::sat16(40'(y_sum >>> 16));

    assign wp_next = (wp_reg == LAST_IDX) ? '0 : (wp_reg + 1'b1);

    always_ff @(posedge aclk) begin
        case (state_reg)
            mfdl_pkg::ST_IDLE: begin
                x_reg    <= s_tdata[15:0];
                mod_reg  <= s_tdata[31:16];
                last_reg <= s_tlast;
            end
            mfdl_pkg::ST_MULT1: begin
                modp_reg <= modp_next;
                fbp_reg  <= fbp_next;
            end
            mfdl_pkg::ST_DIFF: begin
                diff_reg   <= diff_next;
                fbprod_reg <= fbprod_next;
            end
            mfdl_pkg::ST_SMUL:   sprod_reg <= sprod_next;
            mfdl_pkg::ST_SUPD:   wval_reg  <= wval_next;
            mfdl_pkg::ST_OMUL:   oprod_reg <= oprod_next;
            mfdl_pkg::ST_OCLAMP: off_reg   <= off_next;
            mfdl_pkg::ST_RPOS:   rp_reg    <= rp_wrap[OFW-1:0];
            mfdl_pkg::ST_RD1:    y0_reg    <= qv;
            mfdl_pkg::ST_INTERP: iprod_reg <= iprod_next;
            mfdl_pkg::ST_SMP:    smp_reg   <= smp_next;
            mfdl_pkg::ST_MIXM: begin
                px_reg <= px_next;
                ps_reg <= ps_next;
            end
            default: ;
        endcase
        if (mem_rd_en) begin
            rdv_reg <= rdv_next;
        end
        if (out_load) begin
            m_tdata_reg <= y_next;
            m_tlast_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            full_reg     <= 1'b0;
            smoothed_reg <= '0;
            fed_back_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == mfdl_pkg::ST_SUPD) begin
                smoothed_reg <= snew;
            end
            if (state_reg == mfdl_pkg::ST_SMP) begin
                fed_back_reg <= smp_next;
            end
            if (mem_wr_en) begin
                wp_reg <= wp_next;
                if (wp_reg == LAST_IDX) begin
                    full_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- assertions ----------------
    a_rd_wr_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_rd_en && mem_wr_en))
        else $error("store read and write in the same cycle");

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_rd_en |-> (rd_addr <= LAST_IDX))
        else $error("store read address beyond depth");

    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |=> ((wp_reg == $past(wp_reg) + 1'b1) || (wp_reg == '0)))
        else $error("write pointer did not advance by one");

    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |=> full_reg)
        else $error("store full flag dropped");

endmodule
